// File: hw/rtl/assert_macros.svh
// assertion helpers for the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SPGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/spgs_pkg.sv
package spgs_pkg;

    // configuration as seen by the core, already clamped
    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
    } cfg_t;

    // divider request and status
    typedef struct packed {
        logic [16:0] num;
        logic [12:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // one result item
    typedef struct packed {
        logic [5:0] gray;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX,
        ST_PK_TEST,
        ST_PK_RD,
        ST_PK_WR,
        ST_EM_TEST,
        ST_EM_RD,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [2:0] dr;
        logic signed [2:0] dc;
    } off_t;

    localparam int          DIV_STEPS = 6;
    localparam logic [4:0]  PK_LAST   = 5'd8;
    localparam logic [4:0]  EM_LAST   = 5'd24;
    localparam logic [2:0]  WIN_LAST  = 3'd4;
    localparam logic [12:0] NORM_DEN  = 13'd273;

    localparam logic [5:0] GAUSS [5][5] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

    // center first, then the eight neighbors in raster order
    function automatic off_t off3(logic [4:0] idx);
        off_t o;
        case (idx)
            5'd0:    o = '{dr:  3'sd0, dc:  3'sd0};
            5'd1:    o = '{dr: -3'sd1, dc: -3'sd1};
            5'd2:    o = '{dr: -3'sd1, dc:  3'sd0};
            5'd3:    o = '{dr: -3'sd1, dc:  3'sd1};
            5'd4:    o = '{dr:  3'sd0, dc: -3'sd1};
            5'd5:    o = '{dr:  3'sd0, dc:  3'sd1};
            5'd6:    o = '{dr:  3'sd1, dc: -3'sd1};
            5'd7:    o = '{dr:  3'sd1, dc:  3'sd0};
            5'd8:    o = '{dr:  3'sd1, dc:  3'sd1};
            default: o = '{dr:  3'sd0, dc:  3'sd0};
        endcase
        return o;
    endfunction

    // saturation of a >= saturation of b, exact by cross products
    function automatic logic sat_ge(logic [15:0] a, logic [15:0] b);
        logic [7:0]  na, nb, da, db;
        logic [15:0] pa, pb;
        na = a[15:8] - a[7:0];
        nb = b[15:8] - b[7:0];
        da = (a[15:8] != 8'd0) ? a[15:8] : 8'd1;
        db = (b[15:8] != 8'd0) ? b[15:8] : 8'd1;
        pa = 16'(na) * 16'(db);
        pb = 16'(nb) * 16'(da);
        return pa >= pb;
    endfunction

endpackage

// File: hw/rtl/spgs_cfg.sv
module spgs_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output spgs_pkg::cfg_t cfg
);
    import spgs_pkg::*;

    localparam logic [10:0] W_RST = (MAX_WIDTH < 1024) ? 11'(MAX_WIDTH) : 11'd1024;
    localparam logic [10:0] H_RST = (MAX_HEIGHT < 1024) ? 11'(MAX_HEIGHT) : 11'd1024;

    logic [10:0] width_reg, width_next, height_reg, height_next;
    logic        wr_en;

    // zero acts as one, large values saturate
    function automatic logic [10:0] clamp_size(logic [10:0] v, int maxv);
        logic [10:0] s;
        s = (v == 11'd0) ? 11'd1 : v;
        if (int'(s) > maxv) s = 11'(maxv);
        return s;
    endfunction

    assign wr_en = psel && penable && pwrite;

    // register write decode
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en) begin
            if (paddr[2]) height_next = clamp_size(pwdata[10:0], MAX_HEIGHT);
            else          width_next  = clamp_size(pwdata[10:0], MAX_WIDTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= W_RST;
            height_reg <= H_RST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // read back
    assign prdata     = paddr[2] ? {21'd0, height_reg} : {21'd0, width_reg};
    assign pready     = 1'b1;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

// File: hw/rtl/spgs_div.sv
module spgs_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  spgs_pkg::div_req_t  req,
    output spgs_pkg::div_stat_t stat,
    output logic [5:0]          quot
);
    import spgs_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [12:0] den_reg, den_next;
    logic [5:0]  q_reg, q_next;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [17:0] shifted;

    assign shifted = 18'(den_reg) << step_reg;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = req.num;
            den_next  = req.den;
            q_next    = '0;
            step_next = 3'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= shifted) begin
                rem_next         = rem_reg - shifted[16:0];
                q_next[step_reg] = 1'b1;
            end
            if (step_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

// File: hw/rtl/spgs_core.sv
module spgs_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_acc,
    input  logic           item_op,
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    input  spgs_pkg::cfg_t cfg,
    output logic           idle,
    output logic           res_valid,
    output spgs_pkg::res_t res,
    input  logic           res_take
);
    import spgs_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int COLB     = $clog2(MAX_WIDTH + 1);
    localparam int ROWB     = $clog2(MAX_HEIGHT + 1);
    localparam int PB       = $clog2(3 * MAX_WIDTH + 5);
    localparam int CH_DEPTH = 4 * (2 ** CW);
    localparam int PK_DEPTH = 8 * (2 ** CW);

    state_t state_reg, state_next;

    logic [COLB-1:0] cur_w_reg, cur_w_next, in_col_reg, in_col_next;
    logic [COLB-1:0] out_col_reg, out_col_next, pk_col_reg, pk_col_next;
    logic [ROWB-1:0] cur_h_reg, cur_h_next, in_row_reg, in_row_next;
    logic [ROWB-1:0] out_row_reg, out_row_next, pk_row_reg, pk_row_next;
    logic [PB-1:0]   pend_reg, pend_next;
    logic            active_reg, active_next, in_done_reg, in_done_next;
    logic            pk_done_reg, pk_done_next;
    logic [7:0]      mx_reg, mx_next, mn_reg, mn_next;
    logic [4:0]      idx_reg, idx_next;
    logic [2:0]      er_reg, er_next, ec_reg, ec_next;
    logic            vld_d_reg, vld_d_next, first_d_reg, first_d_next;
    logic            last_d_reg, last_d_next, inb_d_reg, inb_d_next;
    logic [5:0]      w_d_reg, w_d_next;
    logic [15:0]     center_reg, center_next;
    logic            peak_reg, peak_next;
    logic [8:0]      sum_reg, sum_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [5:0]      gray_reg, gray_next;

    // line memories
    logic [15:0]     chroma_mem [CH_DEPTH];
    logic            pk_mem [PK_DEPTH];
    logic [CW+1:0]   ch_waddr, ch_raddr;
    logic [CW+2:0]   pk_waddr, pk_raddr;
    logic [15:0]     ch_rdata_reg;
    logic            pk_rdata_reg, ch_we, pk_we;

    // window tap addressing
    off_t                off;
    logic [ROWB-1:0]     base_row;
    logic [COLB-1:0]     base_col;
    logic signed [ROWB+1:0] nr;
    logic signed [COLB+1:0] nc;
    logic            inb, issue, drain_ok, pk_ready, over_thr;
    logic [4:0]      lim;
    logic [ROWB:0]   tr;
    logic [COLB:0]   tc;
    logic [PB-1:0]   thr;

    div_req_t        div_req;
    div_stat_t       div_stat;
    logic [5:0]      quot;
    logic            div_start;

    spgs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .stat    (div_stat),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (ch_we) chroma_mem[ch_waddr] <= {mx_reg, mn_reg};
        ch_rdata_reg <= chroma_mem[ch_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pk_we) pk_mem[pk_waddr] <= peak_reg;
        pk_rdata_reg <= pk_mem[pk_raddr];
    end

    // tap offset and bounds
    always_comb begin
        if (state_reg == ST_EM_RD) begin
            off.dr   = $signed(er_reg) - 3'sd2;
            off.dc   = $signed(ec_reg) - 3'sd2;
            base_row = out_row_reg;
            base_col = out_col_reg;
            lim      = EM_LAST;
        end else begin
            off      = off3(idx_reg);
            base_row = pk_row_reg;
            base_col = pk_col_reg;
            lim      = PK_LAST;
        end
        nr = $signed({2'b00, base_row}) + {{(ROWB-1){off.dr[2]}}, off.dr};
        nc = $signed({2'b00, base_col}) + {{(COLB-1){off.dc[2]}}, off.dc};
        inb = !nr[ROWB+1] && !nc[COLB+1] &&
              (nr < $signed({2'b00, cur_h_reg})) && (nc < $signed({2'b00, cur_w_reg}));
        ch_raddr = {nr[1:0], nc[CW-1:0]};
        pk_raddr = {nr[2:0], nc[CW-1:0]};
        issue    = ((state_reg == ST_PK_RD) || (state_reg == ST_EM_RD)) && (idx_reg <= lim);
    end

    // frame bookkeeping conditions
    always_comb begin
        tr = ({1'b0, pk_row_reg} + 1'b1 < {1'b0, cur_h_reg}) ?
             {1'b0, pk_row_reg} + 1'b1 : {1'b0, cur_h_reg} - 1'b1;
        tc = ({1'b0, pk_col_reg} + 1'b1 < {1'b0, cur_w_reg}) ?
             {1'b0, pk_col_reg} + 1'b1 : {1'b0, cur_w_reg} - 1'b1;
        pk_ready = in_done_reg || ({1'b0, in_row_reg} > tr) ||
                   (({1'b0, in_row_reg} == tr) && ({1'b0, in_col_reg} > tc));
        thr      = PB'({cur_w_reg, 1'b0}) + PB'(cur_w_reg) + PB'(3);
        over_thr = pend_reg > thr;
        drain_ok = active_reg && in_done_reg && (pend_reg != '0);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_acc) begin
                    if (!item_op)      state_next = ST_PIX;
                    else if (drain_ok) state_next = ST_EM_RD;
                end
            end
            ST_PIX:     state_next = ST_PK_TEST;
            ST_PK_TEST: state_next = (pk_done_reg || !pk_ready) ? ST_EM_TEST : ST_PK_RD;
            ST_PK_RD:   if (vld_d_reg && last_d_reg) state_next = ST_PK_WR;
            ST_PK_WR:   state_next = ST_PK_TEST;
            ST_EM_TEST: state_next = over_thr ? ST_EM_RD : ST_IDLE;
            ST_EM_RD:   if (vld_d_reg && last_d_reg) state_next = ST_DSTART;
            ST_DSTART:  state_next = ST_DWAIT;
            ST_DWAIT:   if (div_stat.done) state_next = ST_OUT;
            ST_OUT:     if (res_take) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        cur_w_next   = cur_w_reg;
        cur_h_next   = cur_h_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        pk_row_next  = pk_row_reg;
        pk_col_next  = pk_col_reg;
        pend_next    = pend_reg;
        active_next  = active_reg;
        in_done_next = in_done_reg;
        pk_done_next = pk_done_reg;
        mx_next      = mx_reg;
        mn_next      = mn_reg;
        idx_next     = idx_reg;
        er_next      = er_reg;
        ec_next      = ec_reg;
        center_next  = center_reg;
        peak_next    = peak_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        gray_next    = gray_reg;
        vld_d_next   = issue;
        first_d_next = (idx_reg == 5'd0);
        last_d_next  = (idx_reg == lim);
        inb_d_next   = inb;
        w_d_next     = GAUSS[er_reg][ec_reg];

        // pixel request: channel extremes, frame start
        if (state_reg == ST_IDLE && item_acc && !item_op) begin
            mx_next = red;
            mn_next = red;
            if (green > mx_next) mx_next = green;
            if (blue > mx_next)  mx_next = blue;
            if (green < mn_next) mn_next = green;
            if (blue < mn_next)  mn_next = blue;
            if (!active_reg || in_done_reg) begin
                cur_w_next   = COLB'(cfg.width);
                cur_h_next   = ROWB'(cfg.height);
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                pk_row_next  = '0;
                pk_col_next  = '0;
                pend_next    = '0;
                active_next  = 1'b1;
                in_done_next = 1'b0;
                pk_done_next = 1'b0;
            end
        end

        // input position advance
        if (state_reg == ST_PIX) begin
            pend_next = pend_reg + 1'b1;
            if (in_col_reg + 1'b1 == cur_w_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
                if (in_row_reg + 1'b1 == cur_h_reg) in_done_next = 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        // window walk setup
        if (state_next == ST_PK_RD && state_reg != ST_PK_RD) begin
            idx_next  = '0;
            peak_next = 1'b1;
        end
        if (state_next == ST_EM_RD && state_reg != ST_EM_RD) begin
            idx_next = '0;
            er_next  = '0;
            ec_next  = '0;
            sum_next = '0;
            cnt_next = '0;
        end

        // tap issue
        if (issue) begin
            idx_next = idx_reg + 5'd1;
            if (ec_reg == WIN_LAST) begin
                ec_next = '0;
                er_next = er_reg + 3'd1;
            end else begin
                ec_next = ec_reg + 3'd1;
            end
        end

        // neighbor compare
        if (state_reg == ST_PK_RD && vld_d_reg) begin
            if (first_d_reg) center_next = ch_rdata_reg;
            else if (inb_d_reg && sat_ge(ch_rdata_reg, center_reg)) peak_next = 1'b0;
        end

        // peak accumulate
        if (state_reg == ST_EM_RD && vld_d_reg && inb_d_reg && pk_rdata_reg) begin
            sum_next = sum_reg + 9'(w_d_reg);
            cnt_next = cnt_reg + 5'd1;
        end

        // peak position advance
        if (state_reg == ST_PK_WR) begin
            if (pk_col_reg + 1'b1 == cur_w_reg) begin
                pk_col_next = '0;
                pk_row_next = pk_row_reg + 1'b1;
                if (pk_row_reg + 1'b1 == cur_h_reg) pk_done_next = 1'b1;
            end else begin
                pk_col_next = pk_col_reg + 1'b1;
            end
        end

        if (state_reg == ST_DWAIT && div_stat.done) begin
            gray_next = (cnt_reg == 5'd0) ? 6'd0 : quot;
        end

        // output position advance
        if (state_reg == ST_OUT && res_take) begin
            pend_next = pend_reg - 1'b1;
            if (out_col_reg + 1'b1 == cur_w_reg) begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    // control outputs
    always_comb begin
        idle        = (state_reg == ST_IDLE);
        ch_we       = (state_reg == ST_PIX);
        pk_we       = (state_reg == ST_PK_WR);
        div_start   = (state_reg == ST_DSTART);
        res_valid   = (state_reg == ST_OUT);
        ch_waddr    = {in_row_reg[1:0], in_col_reg[CW-1:0]};
        pk_waddr    = {pk_row_reg[2:0], pk_col_reg[CW-1:0]};
        div_req.num = 17'({sum_reg, 8'b0}) - 17'(sum_reg);
        div_req.den = 13'(cnt_reg) * NORM_DEN;
        res.gray    = gray_reg;
        res.row     = 10'(out_row_reg);
        res.col     = 10'(out_col_reg);
        res.last    = (out_row_reg == cur_h_reg - 1'b1) && (out_col_reg == cur_w_reg - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pk_row_reg  <= '0;
            pk_col_reg  <= '0;
            pend_reg    <= '0;
            cur_w_reg   <= '0;
            cur_h_reg   <= '0;
            active_reg  <= 1'b0;
            in_done_reg <= 1'b0;
            pk_done_reg <= 1'b0;
            idx_reg     <= '0;
            er_reg      <= '0;
            ec_reg      <= '0;
            vld_d_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            pk_row_reg  <= pk_row_next;
            pk_col_reg  <= pk_col_next;
            pend_reg    <= pend_next;
            cur_w_reg   <= cur_w_next;
            cur_h_reg   <= cur_h_next;
            active_reg  <= active_next;
            in_done_reg <= in_done_next;
            pk_done_reg <= pk_done_next;
            idx_reg     <= idx_next;
            er_reg      <= er_next;
            ec_reg      <= ec_next;
            vld_d_reg   <= vld_d_next;
        end
        mx_reg      <= mx_next;
        mn_reg      <= mn_next;
        first_d_reg <= first_d_next;
        last_d_reg  <= last_d_next;
        inb_d_reg   <= inb_d_next;
        w_d_reg     <= w_d_next;
        center_reg  <= center_next;
        peak_reg    <= peak_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        gray_reg    <= gray_next;
    end

endmodule

// File: hw/rtl/saturation_peak_gaussian_splat_top.sv
// Saturation peak Gaussian splat over a raster RGB stream.
// Input channel s_*: one pixel per request (tuser = 0) or a drain tick (tuser = 1).
// Result channel m_*: one splat value per output pixel in raster order, tlast on
// the final pixel of the frame. APB port: frame_width at 0x0, frame_height at 0x4,
// latched when a frame's first pixel arrives.
// The output for pixel k leaves with the request of pixel k + 3*W + 3; after the
// last pixel, each drain tick releases one pending output.
// Items are handled one at a time by a sequencer around two line memories.
// A pixel writes its chroma entry and then evaluates each peak whose window has
// arrived (nine chroma memory reads per 3x3 window); producing a result adds 25
// peak memory reads and a 6-step divider, as does a drain tick that releases one.
// The last pixel of a frame evaluates the peaks still open, up to W+2 of them.
// Reset returns to idle with no frame active; memories are not cleared, entries
// are always written in a frame before they are read.
// A finished result sits in an output register; the next request is accepted
// while it waits, and the sequencer holds at its next result until m_tready.
module saturation_peak_gaussian_splat_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_tuser,   // operation: 0 pixel, 1 drain
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // gray_value[5:0], out_row[15:6], out_col[25:16], zero
    output logic        m_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spgs_pkg::*;

    cfg_t cfg;
    res_t core_res, m_data_reg, m_data_next;
    logic core_idle, core_res_valid, res_take, item_acc, res_wait;
    logic m_valid_reg, m_valid_next;

    spgs_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spgs_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_acc  (item_acc),
        .item_op   (s_tuser),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .cfg       (cfg),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res       (core_res),
        .res_take  (res_take)
    );

    assign s_tready = core_idle;
    assign item_acc = s_tvalid && s_tready;
    assign res_take = !m_valid_reg || m_tready;
    assign res_wait = core_res_valid && !res_take;

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_take) begin
            m_valid_next = core_res_valid;
            if (core_res_valid) m_data_next = core_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.col, m_data_reg.row, m_data_reg.gray};
    assign m_tlast  = m_data_reg.last;

    `include "assert_macros.svh"

    `SPGS_ASSERT_IMP(a_gray_max, aclk, aresetn, m_tvalid, m_tdata[5:0] <= 6'd38)
    `SPGS_ASSERT_IMP(a_idle_no_res, aclk, aresetn, s_tready, !core_res_valid)
    `SPGS_ASSERT_NXT(a_res_hold, aclk, aresetn, res_wait, core_res_valid && $stable(core_res))

endmodule

// File: verif/tb_saturation_peak_gaussian_splat_top.sv
`timescale 1ns / 100ps

module tb_saturation_peak_gaussian_splat_top;
    import spgs_pkg::*;

    localparam int          MAX_W      = 1024;
    localparam int          MAX_H      = 1024;
    localparam logic [2:0]  ADDR_WIDTH  = 3'd0;
    localparam logic [2:0]  ADDR_HEIGHT = 3'd4;
    localparam int          RANDOM_ITEMS = 480;
    localparam int          WIDE_DRAINS  = 256;

    typedef enum logic [1:0] {
        REQ_PIXEL,
        REQ_DRAIN,
        REQ_REG,
        REQ_SETTLE
    } req_kind_t;

    typedef struct {
        req_kind_t   kind;
        logic [31:0] data;
        logic [2:0]  addr;
    } req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    saturation_peak_gaussian_splat_top #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // splat predictor state
    logic [15:0] chroma_mem [4*MAX_W];
    bit          peak_mem [8*MAX_W];
    int unsigned reg_w, reg_h, cur_w, cur_h;
    int unsigned in_r, in_c, out_r, out_c, pk_r, pk_c, n_pend;
    bit          fr_active, in_fin, pk_fin;

    res_t        splat_due_q[$];
    req_t        req_q[$];

    int unsigned n_items, n_results, n_frames, n_errors, n_regs;

    function automatic int unsigned clamp_dim(logic [31:0] v, int unsigned maxv);
        int unsigned s;
        s = v[10:0];
        if (s == 0) s = 1;
        if (s > maxv) s = maxv;
        return s;
    endfunction

    // saturation of a is not below saturation of b
    function automatic bit sat_not_below(logic [15:0] a, logic [15:0] b);
        int unsigned ma, mb, na, nb, da, db;
        ma = a[15:8];
        mb = b[15:8];
        na = ma - a[7:0];
        nb = mb - b[7:0];
        da = (ma != 0) ? ma : 1;
        db = (mb != 0) ? mb : 1;
        return na * db >= nb * da;
    endfunction

    function automatic int unsigned gauss_w(int dr, int dc);
        int unsigned k [5] = '{1, 4, 7, 4, 1};
        int unsigned g;
        g = k[dr + 2] * k[dc + 2];
        // the kernel center and its ring are not separable products
        if (g == 49) g = 41;
        else if (g == 28) g = 26;
        return g;
    endfunction

    task automatic mark_peak(int r, int c);
        logic [15:0] ctr;
        bit          pk;
        int          nr, nc;
        ctr = chroma_mem[(r % 4) * MAX_W + c];
        pk = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if (dr == 0 && dc == 0) continue;
                if (nr < 0 || nc < 0 || nr >= int'(cur_h) || nc >= int'(cur_w)) continue;
                if (sat_not_below(chroma_mem[(nr % 4) * MAX_W + nc], ctr)) pk = 1'b0;
            end
        end
        peak_mem[(r % 8) * MAX_W + c] = pk;
    endtask

    // evaluate peaks whose 3x3 neighborhood has fully arrived
    task automatic catch_up_peaks();
        int unsigned tr, tc;
        while (!pk_fin) begin
            tr = (pk_r + 1 < cur_h) ? pk_r + 1 : cur_h - 1;
            tc = (pk_c + 1 < cur_w) ? pk_c + 1 : cur_w - 1;
            if (!in_fin && !(in_r > tr || (in_r == tr && in_c > tc))) break;
            mark_peak(pk_r, pk_c);
            pk_c++;
            if (pk_c == cur_w) begin
                pk_c = 0;
                pk_r++;
                if (pk_r == cur_h) pk_fin = 1'b1;
            end
        end
    endtask

    task automatic push_splat();
        int unsigned sum, cnt;
        int          nr, nc;
        res_t        e;
        sum = 0;
        cnt = 0;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                nr = int'(out_r) + dr;
                nc = int'(out_c) + dc;
                if (nr < 0 || nc < 0 || nr >= int'(cur_h) || nc >= int'(cur_w)) continue;
                if (peak_mem[(nr % 8) * MAX_W + nc]) begin
                    sum += gauss_w(dr, dc);
                    cnt++;
                end
            end
        end
        e.gray = (cnt != 0) ? 6'((sum * 255) / (cnt * 273)) : 6'd0;
        e.row  = 10'(out_r);
        e.col  = 10'(out_c);
        e.last = (out_r == cur_h - 1 && out_c == cur_w - 1);
        splat_due_q.insert(splat_due_q.size(), e);
        out_c++;
        if (out_c == cur_w) begin
            out_c = 0;
            out_r++;
        end
        n_pend--;
    endtask

    // one accepted request through the predictor
    task automatic splat_step(logic drain, logic [23:0] px);
        logic [7:0] rd, gr, bl, mx, mn;
        if (!drain) begin
            rd = px[7:0];
            gr = px[15:8];
            bl = px[23:16];
            if (!fr_active || in_fin) begin
                cur_w = reg_w;
                cur_h = reg_h;
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
                pk_r = 0; pk_c = 0; n_pend = 0;
                fr_active = 1'b1;
                in_fin = 1'b0;
                pk_fin = 1'b0;
                n_frames++;
            end
            mx = rd; mn = rd;
            if (gr > mx) mx = gr;
            if (bl > mx) mx = bl;
            if (gr < mn) mn = gr;
            if (bl < mn) mn = bl;
            chroma_mem[(in_r % 4) * MAX_W + in_c] = {mx, mn};
            in_c++;
            if (in_c == cur_w) begin
                in_c = 0;
                in_r++;
                if (in_r == cur_h) in_fin = 1'b1;
            end
            n_pend++;
            catch_up_peaks();
            if (n_pend > 3 * cur_w + 3) push_splat();
        end else if (fr_active && in_fin && n_pend > 0) begin
            push_splat();
        end
    endtask

    // driver: requests from the queue in bursts, register writes, settle pauses
    bit          loaded;
    int unsigned burst_left, gap_left, settle_left;
    req_t        cur_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            psel        <= 1'b0;
            penable     <= 1'b0;
            pwrite      <= 1'b0;
            loaded      = 1'b0;
            burst_left  = 8;
            gap_left    = 0;
            settle_left = 0;
        end else begin
            // request taken by the block
            if (s_tvalid && s_tready) begin
                splat_step(s_tuser, s_tdata);
                loaded = 1'b0;
                n_items++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else if (gap_left > 0) begin
                gap_left--;
            end

            if (psel && penable) begin
                if (pready && pwrite) begin
                    if (paddr == ADDR_WIDTH) reg_w = clamp_dim(pwdata, MAX_W);
                    else if (paddr == ADDR_HEIGHT) reg_h = clamp_dim(pwdata, MAX_H);
                    n_regs++;
                end
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
            end else if (psel) begin
                penable <= 1'b1;
            end else if (settle_left > 0) begin
                settle_left--;
            end else if (!loaded && req_q.size() > 0) begin
                case (req_q[0].kind)
                    REQ_SETTLE: begin
                        if (splat_due_q.size() == 0) begin
                            settle_left = 12 * (cur_w + 2) + 100;
                            void'(req_q.pop_front());
                        end
                    end
                    REQ_REG: begin
                        cur_req = req_q.pop_front();
                        psel   <= 1'b1;
                        pwrite <= 1'b1;
                        paddr  <= cur_req.addr;
                        pwdata <= cur_req.data;
                    end
                    default: begin
                        cur_req = req_q.pop_front();
                        s_tdata <= cur_req.data[23:0];
                        s_tuser <= (cur_req.kind == REQ_DRAIN);
                        loaded = 1'b1;
                    end
                endcase
            end
            s_tvalid <= loaded && (gap_left == 0);
        end
    end

    // monitor: result checks and receiver stalls
    int unsigned stall_left, stall_mode;
    res_t        due;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
            stall_mode = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (splat_due_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tdata=%h tlast=%b",
                             $time, m_tdata, m_tlast);
                    n_errors++;
                end else begin
                    due = splat_due_q.pop_front();
                    if (m_tdata[5:0] !== due.gray || m_tdata[15:6] !== due.row ||
                        m_tdata[25:16] !== due.col || m_tdata[31:26] !== 6'd0 ||
                        m_tlast !== due.last) begin
                        $display("%0t: mismatch: expected gray=%0d row=%0d col=%0d last=%b,",
                                 $time, due.gray, due.row, due.col, due.last,
                                 " actual gray=%0d row=%0d col=%0d last=%b pad=%h",
                                 m_tdata[5:0], m_tdata[15:6], m_tdata[25:16], m_tlast,
                                 m_tdata[31:26]);
                        n_errors++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(1, 40);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void add_req(req_kind_t k, logic [31:0] d, logic [2:0] a);
        req_t r;
        r.kind = k;
        r.data = d;
        r.addr = a;
        req_q.insert(req_q.size(), r);
    endfunction

    function automatic logic [23:0] rand_pixel(int unsigned style);
        logic [7:0] g;
        case (style)
            0: return 24'($urandom);
            1: begin
                // mostly gray with sparse saturated spots
                if ($urandom_range(0, 5) == 0) return 24'($urandom);
                g = 8'($urandom_range(0, 255));
                return {g, g, g};
            end
            default: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                             {8{$urandom_range(0, 1) == 1}}};
        endcase
    endfunction

    // stimulus
    int unsigned gw, gh, npx, pend, style, ending, early_at, stim_count;
    bit          drained;

    initial begin
        n_items = 0; n_results = 0; n_frames = 0; n_errors = 0; n_regs = 0;
        reg_w = MAX_W; reg_h = MAX_H;
        cur_w = 0; cur_h = 0; fr_active = 1'b0; in_fin = 1'b0; pk_fin = 1'b0;

        // directed: drain before any frame, extreme pixels, drain mid-frame, extra drains
        add_req(REQ_DRAIN, 0, 0);
        add_req(REQ_SETTLE, 0, 0);
        add_req(REQ_REG, 1024, ADDR_HEIGHT);
        add_req(REQ_REG, 3, ADDR_WIDTH);
        add_req(REQ_REG, 3, ADDR_HEIGHT);
        add_req(REQ_PIXEL, 24'h000000, 0);
        add_req(REQ_PIXEL, 24'hFFFFFF, 0);
        add_req(REQ_PIXEL, 24'h0000FF, 0);
        add_req(REQ_PIXEL, 24'h00FF00, 0);
        add_req(REQ_DRAIN, 0, 0);
        add_req(REQ_PIXEL, 24'hFF0000, 0);
        add_req(REQ_PIXEL, 24'h004080, 0);
        add_req(REQ_PIXEL, 24'h000001, 0);
        add_req(REQ_PIXEL, 24'hFFFEFF, 0);
        add_req(REQ_PIXEL, 24'h3264C8, 0);
        for (int i = 0; i < 10; i++) add_req(REQ_DRAIN, 0, 0);

        // random frames, mostly small
        gw = 3; gh = 3; drained = 1'b1; stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            if (drained && $urandom_range(0, 2) != 0) begin
                add_req(REQ_SETTLE, 0, 0);
                gw = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
                gh = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
                // a written zero acts as one
                add_req(REQ_REG, (gw == 1 && $urandom_range(0, 1)) ? 0 : gw, ADDR_WIDTH);
                if ($urandom_range(0, 7) == 0) add_req(REQ_REG, 2047, ADDR_HEIGHT);
                add_req(REQ_REG, (gh == 1 && $urandom_range(0, 1)) ? 0 : gh, ADDR_HEIGHT);
            end
            npx = gw * gh;
            style = $urandom_range(0, 2);
            early_at = ($urandom_range(0, 9) == 0 && npx > 1) ? $urandom_range(1, npx - 1) : 0;
            for (int i = 0; i < int'(npx); i++) begin
                if (early_at != 0 && i == int'(early_at)) begin
                    add_req(REQ_DRAIN, 0, 0);
                    stim_count++;
                end
                add_req(REQ_PIXEL, rand_pixel(style), 0);
                stim_count++;
            end
            pend = (npx < 3 * gw + 3) ? npx : 3 * gw + 3;
            ending = $urandom_range(0, 9);
            if (ending < 7) begin
                pend += $urandom_range(0, 2);
                drained = 1'b1;
            end else if (ending < 9) begin
                // next frame starts with outputs still pending
                pend = $urandom_range(0, pend - 1);
                drained = 1'b0;
            end else begin
                pend = 0;
                drained = 1'b0;
            end
            for (int i = 0; i < int'(pend); i++) add_req(REQ_DRAIN, 0, 0);
            stim_count += pend;
        end

        // widest frame, one row; sizes written out of range; drained only in part
        add_req(REQ_SETTLE, 0, 0);
        add_req(REQ_REG, 2047, ADDR_WIDTH);
        add_req(REQ_REG, 0, ADDR_HEIGHT);
        for (int i = 0; i < MAX_W; i++) add_req(REQ_PIXEL, rand_pixel($urandom_range(0, 2)), 0);
        for (int i = 0; i < WIDE_DRAINS; i++) add_req(REQ_DRAIN, 0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() > 0 || loaded || psel || splat_due_q.size() > 0) @(posedge aclk);
        repeat (12 * (cur_w + 2) + 100) @(posedge aclk);

        if (splat_due_q.size() > 0) begin
            $display("%0t: %0d expected results never arrived, first expected row=%0d col=%0d",
                     $time, splat_due_q.size(), splat_due_q[0].row, splat_due_q[0].col);
            n_errors++;
        end
        $display("covered %0d requests over %0d frames, %0d results checked, %0d register writes",
                 n_items, n_frames, n_results, n_regs);
        $display("sizes from 1x1 up to a 1024-wide row, drains early, late and cut short");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // timeout
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/spgs_pkg.sv
hw/rtl/spgs_cfg.sv
hw/rtl/spgs_div.sv
hw/rtl/spgs_core.sv
hw/rtl/saturation_peak_gaussian_splat_top.sv
verif/tb_saturation_peak_gaussian_splat_top.sv
